// ----- rtl/core/spq_pkg.sv -----
// shared types and constants of the speedup priority task queue
// no dependencies; used by the interfaces, the cell and the top level
package spq_pkg;

   localparam int HANDLE_BITS    = 16;
   localparam int FRAC_BITS      = 8;
   localparam int GPU_COUNT_BITS = 8;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 8;
   localparam int STATUS_BITS    = 3;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_INSERTED = 3'd0,
      ST_GRANTED  = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_HELD     = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_TAKE   = 1'b1
   } op_type;

   typedef enum logic {
      KIND_CPU = 1'b0,
      KIND_GPU = 1'b1
   } kind_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_BALANCE_ENABLE   = 1'b0,
      CSR_GPU_THREAD_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_EVAL = 2'd1,
      S_EXEC = 2'd2,
      S_RESP = 2'd3
   } state_type;

   // per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic insert;
      logic drop_front;
   } cell_ctrl_type;

endpackage

// ----- rtl/core/spq_if.sv -----
// request and response channel interfaces of the speedup priority task queue
// depends on spq_pkg
interface spq_req_if #(parameter int KEY_BITS = 16);
   logic                             valid;
   logic                             ready;
   logic                             op;
   logic [spq_pkg::HANDLE_BITS-1:0]  task_handle;
   logic [KEY_BITS-1:0]              speedup_key;
   logic                             requester_kind;

   modport source(output valid, op, task_handle, speedup_key, requester_kind, input ready);
   modport sink(input valid, op, task_handle, speedup_key, requester_kind, output ready);
endinterface

interface spq_rsp_if #(parameter int KEY_BITS = 16, parameter int COUNT_BITS = 6);
   logic                             valid;
   logic                             ready;
   logic [spq_pkg::STATUS_BITS-1:0]  status;
   logic [spq_pkg::HANDLE_BITS-1:0]  granted_handle;
   logic [KEY_BITS-1:0]              granted_key;
   logic [COUNT_BITS-1:0]            entry_count;
   logic                             ends_valid;
   logic [KEY_BITS-1:0]              front_key;
   logic [KEY_BITS-1:0]              back_key;

   modport source(output valid, status, granted_handle, granted_key, entry_count, ends_valid,
                  front_key, back_key, input ready);
   modport sink(input valid, status, granted_handle, granted_key, entry_count, ends_valid,
                front_key, back_key, output ready);
endinterface

// ----- rtl/core/speedup_priority_task_queue.sv -----
// Speedup priority task queue: tasks sorted by key in a chain of cells.
// Each accepted request steps through evaluate, execute and respond; no new request is taken
// until idle. The response word is registered in respond, once any earlier word is taken.
// Reset (synchronous): count, sequencer, response valid and config registers clear;
// cell contents are not cleared and are only read below the count.
module speedup_priority_task_queue #(
   parameter int CAPACITY = 32,
   parameter int KEY_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [spq_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [spq_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   spq_req_if.sink                            req,
   spq_rsp_if.source                          rsp
);

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int HB   = spq_pkg::HANDLE_BITS;
   localparam int PW   = spq_pkg::GPU_COUNT_BITS + KEY_BITS;
   localparam int CMPW = PW + CW + spq_pkg::FRAC_BITS;

   spq_pkg::state_type state_ff, state_in;

   // configuration registers
   logic                                  balance_ff;
   logic [spq_pkg::GPU_COUNT_BITS-1:0]    gpu_count_ff;

   // accepted request
   spq_pkg::op_type                       op_ff;
   spq_pkg::kind_type                     kind_ff;
   logic [HB-1:0]                         handle_ff;
   logic [KEY_BITS-1:0]                   key_ff;

   logic [CW-1:0]                         occ_ff, occ_in;
   logic [PW-1:0]                         prod_ff;
   logic [KEY_BITS-1:0]                   tail_key_ff;
   logic [HB-1:0]                         tail_handle_ff;

   spq_pkg::status_type                   status_ff, status_in;
   logic [HB-1:0]                         ghandle_ff, ghandle_in;
   logic [KEY_BITS-1:0]                   gkey_ff, gkey_in;

   // response register
   logic                                  rsp_valid_ff;
   spq_pkg::status_type                   rsp_status_ff;
   logic [HB-1:0]                         rsp_ghandle_ff;
   logic [KEY_BITS-1:0]                   rsp_gkey_ff;
   logic [CW-1:0]                         rsp_count_ff;
   logic                                  rsp_ends_ff;
   logic [KEY_BITS-1:0]                   rsp_front_ff;
   logic [KEY_BITS-1:0]                   rsp_back_ff;

   spq_pkg::cell_ctrl_type                ctrl;
   logic                                  rsp_load;
   logic                                  held;

   logic                                  cell_gt     [CAPACITY];
   logic [KEY_BITS-1:0]                   cell_key    [CAPACITY];
   logic [HB-1:0]                         cell_handle [CAPACITY];
   logic [KEY_BITS-1:0]                   sel_key;
   logic [HB-1:0]                         sel_handle;

   // the chain of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                gt_left;
      logic [KEY_BITS-1:0] key_left, key_right;
      logic [HB-1:0]       handle_left, handle_right;

      if (i == 0) begin : g_first
         assign gt_left     = 1'b0;
         assign key_left    = '0;
         assign handle_left = '0;
      end else begin : g_inner_left
         assign gt_left     = cell_gt[i-1];
         assign key_left    = cell_key[i-1];
         assign handle_left = cell_handle[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign key_right    = '0;
         assign handle_right = '0;
      end else begin : g_inner_right
         assign key_right    = cell_key[i+1];
         assign handle_right = cell_handle[i+1];
      end

      spq_cell #(.KEY_BITS(KEY_BITS)) u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .is_valid     (CW'(i) < occ_ff),
         .is_append    (CW'(i) == occ_ff),
         .new_key      (key_ff),
         .new_handle   (handle_ff),
         .left_gt      (gt_left),
         .left_key     (key_left),
         .left_handle  (handle_left),
         .right_key    (key_right),
         .right_handle (handle_right),
         .gt           (cell_gt[i]),
         .key          (cell_key[i]),
         .handle       (cell_handle[i])
      );
   end

   // pick the last occupied cell: one-hot and-or select
   always_comb begin
      sel_key    = '0;
      sel_handle = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (CW'(i + 1) == occ_ff) begin
            sel_key    = sel_key | cell_key[i];
            sel_handle = sel_handle | cell_handle[i];
         end
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         balance_ff   <= 1'b0;
         gpu_count_ff <= '0;
      end else if (csr_we) begin
         case (spq_pkg::csr_index_type'(csr_index))
            spq_pkg::CSR_BALANCE_ENABLE:   balance_ff   <= csr_wdata[0];
            spq_pkg::CSR_GPU_THREAD_COUNT: gpu_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spq_pkg::S_IDLE: if (req.valid) state_in = spq_pkg::S_EVAL;
         spq_pkg::S_EVAL: state_in = spq_pkg::S_EXEC;
         spq_pkg::S_EXEC: state_in = spq_pkg::S_RESP;
         spq_pkg::S_RESP: if (rsp_load) state_in = spq_pkg::S_IDLE;
         default:         state_in = spq_pkg::S_IDLE;
      endcase
   end

   // balancing: thread count times front key against count scaled by 2^8
   assign held = balance_ff &&
                 (CMPW'(prod_ff) > (CMPW'(occ_ff) << spq_pkg::FRAC_BITS));

   // sequencer outputs
   always_comb begin
      ctrl       = '0;
      occ_in     = occ_ff;
      status_in  = status_ff;
      ghandle_in = ghandle_ff;
      gkey_in    = gkey_ff;
      rsp_load   = 1'b0;
      case (state_ff)
         spq_pkg::S_EXEC: begin
            ghandle_in = '0;
            gkey_in    = '0;
            if (op_ff == spq_pkg::OP_INSERT) begin
               if (occ_ff == CW'(CAPACITY)) begin
                  status_in = spq_pkg::ST_FULL;
               end else begin
                  status_in   = spq_pkg::ST_INSERTED;
                  ctrl.insert = 1'b1;
                  occ_in      = occ_ff + CW'(1);
               end
            end else if (occ_ff == '0) begin
               status_in = spq_pkg::ST_EMPTY;
            end else if (kind_ff == spq_pkg::KIND_GPU) begin
               status_in  = spq_pkg::ST_GRANTED;
               ghandle_in = tail_handle_ff;
               gkey_in    = tail_key_ff;
               occ_in     = occ_ff - CW'(1);
            end else if (held) begin
               status_in = spq_pkg::ST_HELD;
            end else begin
               status_in       = spq_pkg::ST_GRANTED;
               ghandle_in      = cell_handle[0];
               gkey_in         = cell_key[0];
               ctrl.drop_front = 1'b1;
               occ_in          = occ_ff - CW'(1);
            end
         end
         spq_pkg::S_RESP: rsp_load = !rsp_valid_ff || rsp.ready;
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spq_pkg::S_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == spq_pkg::S_IDLE && req.valid) begin
         op_ff     <= spq_pkg::op_type'(req.op);
         kind_ff   <= spq_pkg::kind_type'(req.requester_kind);
         handle_ff <= req.task_handle;
         key_ff    <= req.speedup_key;
      end
      if (state_ff == spq_pkg::S_EVAL) begin
         prod_ff        <= PW'(gpu_count_ff) * PW'(cell_key[0]);
         tail_key_ff    <= sel_key;
         tail_handle_ff <= sel_handle;
      end
      status_ff  <= status_in;
      ghandle_ff <= ghandle_in;
      gkey_ff    <= gkey_in;
      if (rsp_load) begin
         rsp_status_ff  <= status_ff;
         rsp_ghandle_ff <= ghandle_ff;
         rsp_gkey_ff    <= gkey_ff;
         rsp_count_ff   <= occ_ff;
         rsp_ends_ff    <= (occ_ff != '0);
         rsp_front_ff   <= (occ_ff != '0) ? cell_key[0] : '0;
         rsp_back_ff    <= (occ_ff != '0) ? sel_key : '0;
      end
   end

   assign req.ready          = (state_ff == spq_pkg::S_IDLE) && !reset;
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.status         = rsp_status_ff;
   assign rsp.granted_handle = rsp_ghandle_ff;
   assign rsp.granted_key    = rsp_gkey_ff;
   assign rsp.entry_count    = rsp_count_ff;
   assign rsp.ends_valid     = rsp_ends_ff;
   assign rsp.front_key      = rsp_front_ff;
   assign rsp.back_key       = rsp_back_ff;

`ifndef SYNTHESIS
   // the count never runs past the chain length
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CW'(CAPACITY))
      else $error("queue count beyond capacity");

   // a new response word only comes out of the respond step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == spq_pkg::S_RESP))
      else $error("response raised outside respond step");

   // the cells only move in the execute step
   a_ctrl_exec: assert property (@(posedge clock) disable iff (reset)
      (ctrl.insert || ctrl.drop_front) |-> (state_ff == spq_pkg::S_EXEC))
      else $error("cell shift outside execute step");

   // ends flag follows the reported count
   a_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ends_ff == (rsp_count_ff != '0)))
      else $error("ends flag disagrees with count");
`endif

endmodule

// ----- rtl/core/spq_cell.sv -----
// one slot of the sorted chain: holds a key and a handle
// depends on spq_pkg; shifts right on insert, left on a front pop
module spq_cell #(
   parameter int KEY_BITS = 16
) (
   input  logic                            clock,
   input  spq_pkg::cell_ctrl_type          ctrl,
   input  logic                            is_valid,
   input  logic                            is_append,
   input  logic [KEY_BITS-1:0]             new_key,
   input  logic [spq_pkg::HANDLE_BITS-1:0] new_handle,
   input  logic                            left_gt,
   input  logic [KEY_BITS-1:0]             left_key,
   input  logic [spq_pkg::HANDLE_BITS-1:0] left_handle,
   input  logic [KEY_BITS-1:0]             right_key,
   input  logic [spq_pkg::HANDLE_BITS-1:0] right_handle,
   output logic                            gt,
   output logic [KEY_BITS-1:0]             key,
   output logic [spq_pkg::HANDLE_BITS-1:0] handle
);

   logic [KEY_BITS-1:0]             key_ff, key_in;
   logic [spq_pkg::HANDLE_BITS-1:0] handle_ff, handle_in;

   // occupied and strictly larger than the incoming key: this entry moves right
   assign gt = is_valid && (key_ff > new_key);

   // next contents
   always_comb begin
      key_in    = key_ff;
      handle_in = handle_ff;
      if (ctrl.insert) begin
         if (left_gt) begin
            key_in    = left_key;
            handle_in = left_handle;
         end else if (gt || is_append) begin
            key_in    = new_key;
            handle_in = new_handle;
         end
      end else if (ctrl.drop_front) begin
         key_in    = right_key;
         handle_in = right_handle;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      handle_ff <= handle_in;
   end

   assign key    = key_ff;
   assign handle = handle_ff;

endmodule

// ----- tb/tb_speedup_priority_task_queue.sv -----
// self-checking testbench of speedup_priority_task_queue: random and directed task words
// depends on spq_pkg, spq_req_if, spq_rsp_if and the queue itself
module tb_speedup_priority_task_queue;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY    = 32;
   localparam int KEY_BITS    = 16;
   localparam int LATENCY     = 3;
   localparam int CYCLE_LIMIT = 300000;
   localparam int PHASES      = 12;
   localparam int PHASE_WORDS = 100;

   typedef struct packed {
      spq_pkg::op_type     op;
      logic [15:0]         task_handle;
      logic [KEY_BITS-1:0] speedup_key;
      spq_pkg::kind_type   requester_kind;
   } task_word_type;

   typedef struct packed {
      spq_pkg::status_type status;
      logic [15:0]         granted_handle;
      logic [KEY_BITS-1:0] granted_key;
      logic [5:0]          entry_count;
      logic                ends_valid;
      logic [KEY_BITS-1:0] front_key;
      logic [KEY_BITS-1:0] back_key;
   } outcome_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_we;
   logic [0:0] csr_index;
   logic [7:0] csr_wdata;

   spq_req_if #(.KEY_BITS(KEY_BITS)) req_bus();
   spq_rsp_if #(.KEY_BITS(KEY_BITS), .COUNT_BITS(6)) rsp_bus();

   speedup_priority_task_queue #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) uut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req(req_bus),
      .rsp(rsp_bus)
   );

   // shadow copy of the sorted store and the registers
   logic [KEY_BITS-1:0] shadow_keys[CAPACITY];
   logic [15:0]         shadow_handles[CAPACITY];
   int                  shadow_fill;
   bit                  balance_on;
   logic [7:0]          gpu_threads;

   task_word_type pending_words[$];
   outcome_type   expected_outcomes[$];
   task_word_type cur_word;
   int            words_planned;
   int            words_sent;
   int            results_seen;
   int            mismatches;
   int            status_seen[5];
   int            settings_run;
   int            cycles;
   int            gap_left;
   int            stall_left;
   int            hold_count;
   bit            hold_done;
   bit            rsp_hold;
   bit            req_busy;
   bit            steady;

   always #5 clock = ~clock;

   // next state of the queue for one accepted word
   function automatic outcome_type schedule_word(task_word_type w);
      outcome_type         o;
      int                  pos;
      logic [23:0]         demand;
      logic [23:0]         supply;
      o = '0;
      if (w.op == spq_pkg::OP_INSERT) begin
         if (shadow_fill >= CAPACITY) begin
            o.status = spq_pkg::ST_FULL;
         end else begin
            // equal keys stay in arrival order: stop at the first key not above ours
            pos = shadow_fill;
            while (pos > 0 && shadow_keys[pos-1] > w.speedup_key) begin
               shadow_keys[pos]    = shadow_keys[pos-1];
               shadow_handles[pos] = shadow_handles[pos-1];
               pos--;
            end
            shadow_keys[pos]    = w.speedup_key;
            shadow_handles[pos] = w.task_handle;
            shadow_fill++;
            o.status = spq_pkg::ST_INSERTED;
         end
      end else if (shadow_fill == 0) begin
         o.status = spq_pkg::ST_EMPTY;
      end else if (w.requester_kind == spq_pkg::KIND_GPU) begin
         // gpu takes the largest key
         o.status         = spq_pkg::ST_GRANTED;
         o.granted_handle = shadow_handles[shadow_fill-1];
         o.granted_key    = shadow_keys[shadow_fill-1];
         shadow_fill--;
      end else begin
         // cpu takes the smallest key unless the gpu side would do better
         demand = gpu_threads * shadow_keys[0];
         supply = 24'(shadow_fill) << spq_pkg::FRAC_BITS;
         if (balance_on && demand > supply) begin
            o.status = spq_pkg::ST_HELD;
         end else begin
            o.status         = spq_pkg::ST_GRANTED;
            o.granted_handle = shadow_handles[0];
            o.granted_key    = shadow_keys[0];
            for (int i = 0; i + 1 < shadow_fill; i++) begin
               shadow_keys[i]    = shadow_keys[i+1];
               shadow_handles[i] = shadow_handles[i+1];
            end
            shadow_fill--;
         end
      end
      o.entry_count = 6'(shadow_fill);
      if (shadow_fill > 0) begin
         o.ends_valid = 1'b1;
         o.front_key  = shadow_keys[0];
         o.back_key   = shadow_keys[shadow_fill-1];
      end
      return o;
   endfunction

   function automatic int idle_draw();
      return steady ? 0 : $urandom_range(0, 8);
   endfunction

   task automatic note_mismatch(string what, outcome_type want, outcome_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch (%s) at word %0d", what, results_seen);
         $display("  expected st=%0d h=%h k=%h n=%0d v=%b f=%h b=%h",
                  want.status, want.granted_handle, want.granted_key,
                  want.entry_count, want.ends_valid, want.front_key, want.back_key);
         $display("  got      st=%0d h=%h k=%h n=%0d v=%b f=%h b=%h",
                  got.status, got.granted_handle, got.granted_key, got.entry_count,
                  got.ends_valid, got.front_key, got.back_key);
      end
   endtask

   // request driver: one word at a time, random gap after each accepted word unless steady
   always @(posedge clock) begin : driver
      bit next_valid;
      next_valid = req_busy;
      if (reset) begin
         next_valid = 1'b0;
         gap_left   = 0;
         req_bus.op             <= spq_pkg::OP_INSERT;
         req_bus.task_handle    <= '0;
         req_bus.speedup_key    <= '0;
         req_bus.requester_kind <= spq_pkg::KIND_CPU;
      end else begin
         if (req_busy && req_bus.ready) begin
            expected_outcomes.insert(expected_outcomes.size(), schedule_word(cur_word));
            words_sent++;
            next_valid = 1'b0;
            gap_left   = idle_draw();
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_words.size() > 0) begin
               cur_word = pending_words[0];
               pending_words.delete(0);
               req_bus.op             <= cur_word.op;
               req_bus.task_handle    <= cur_word.task_handle;
               req_bus.speedup_key    <= cur_word.speedup_key;
               req_bus.requester_kind <= cur_word.requester_kind;
               next_valid = 1'b1;
            end
         end
      end
      req_busy = next_valid;
      req_bus.valid <= next_valid;
   end

   // long response hold-off once, while the driver keeps offering words
   always @(posedge clock) begin : backpressure
      bit hold_next;
      hold_next = 1'b0;
      if (!reset) begin
         if (hold_count > 0) begin
            hold_count--;
            hold_next = (hold_count > 0);
         end else if (!hold_done && words_sent >= 600) begin
            hold_done  = 1'b1;
            hold_count = 150;
            hold_next  = 1'b1;
         end
      end
      rsp_hold <= hold_next;
   end

   // response monitor: compare each word with the oldest expectation
   always @(posedge clock) begin : monitor
      outcome_type got;
      outcome_type want;
      if (reset) begin
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.status         = spq_pkg::status_type'(rsp_bus.status);
            got.granted_handle = rsp_bus.granted_handle;
            got.granted_key    = rsp_bus.granted_key;
            got.entry_count    = rsp_bus.entry_count;
            got.ends_valid     = rsp_bus.ends_valid;
            got.front_key      = rsp_bus.front_key;
            got.back_key       = rsp_bus.back_key;
            if (rsp_bus.status < 5)
               status_seen[rsp_bus.status]++;
            if (expected_outcomes.size() == 0) begin
               note_mismatch("unexpected", '0, got);
            end else begin
               want = expected_outcomes[0];
               expected_outcomes.delete(0);
               if (got !== want)
                  note_mismatch("field", want, got);
            end
            results_seen++;
            stall_left = idle_draw();
         end else if (stall_left > 0) begin
            stall_left--;
         end
      end
      rsp_bus.ready <= !reset && stall_left == 0 && !rsp_hold;
   end

   // watchdog
   always @(posedge clock) begin : watchdog
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still expected", cycles,
                  expected_outcomes.size());
         $display("FAILURE");
         $finish;
      end
   end

   task automatic add_word(spq_pkg::op_type op, logic [15:0] handle,
                           logic [KEY_BITS-1:0] key, spq_pkg::kind_type kind);
      task_word_type w;
      w.op             = op;
      w.task_handle    = handle;
      w.speedup_key    = key;
      w.requester_kind = kind;
      pending_words.insert(pending_words.size(), w);
      words_planned++;
   endtask

   // random word: op mix set per phase, keys biased toward ties and the balance threshold
   task automatic add_random_word(int insert_pct);
      logic [KEY_BITS-1:0] key;
      logic [KEY_BITS-1:0] tie_keys[4];
      tie_keys = '{16'h0080, 16'h0100, 16'h0180, 16'h0200};
      case ($urandom_range(0, 7))
         0: key = tie_keys[$urandom_range(0, 3)];
         1: key = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         2, 3: key = 16'($urandom_range(0, 16'h0400));
         default: key = 16'($urandom);
      endcase
      add_word(($urandom_range(0, 99) < insert_pct) ? spq_pkg::OP_INSERT : spq_pkg::OP_TAKE,
               16'($urandom), key, spq_pkg::kind_type'($urandom_range(0, 1)));
   endtask

   // wait until every word is answered, then let the sequencer settle
   task automatic wait_idle();
      while (words_sent != words_planned || expected_outcomes.size() != 0)
         @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);
   endtask

   task automatic write_csr(spq_pkg::csr_index_type idx, logic [7:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == spq_pkg::CSR_BALANCE_ENABLE)
         balance_on = value[0];
      else
         gpu_threads = value;
   endtask

   task automatic set_balance(bit enable, logic [7:0] threads);
      wait_idle();
      write_csr(spq_pkg::CSR_BALANCE_ENABLE, {7'd0, enable});
      write_csr(spq_pkg::CSR_GPU_THREAD_COUNT, threads);
      settings_run++;
   endtask

   initial begin
      bit          bal_list[PHASES];
      logic [7:0]  thr_list[PHASES];
      int          pct_list[6];
      bal_list = '{0, 1, 1, 0, 1, 1, 1, 1, 0, 1, 1, 1};
      thr_list = '{8'd0, 8'd8, 8'd255, 8'd255, 8'd0, 8'd1, 8'd32, 8'd4, 8'd17, 8'd128,
                   8'd2, 8'd16};
      pct_list = '{50, 85, 30, 60, 15, 70};

      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      balance_on   = 1'b0;
      gpu_threads  = '0;
      settings_run = 1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // takes from an empty queue, extreme keys, ties kept in arrival order
      add_word(spq_pkg::OP_TAKE,   16'h0000, 16'h0000, spq_pkg::KIND_CPU);
      add_word(spq_pkg::OP_TAKE,   16'hFFFF, 16'hFFFF, spq_pkg::KIND_GPU);
      add_word(spq_pkg::OP_INSERT, 16'h0000, 16'h0000, spq_pkg::KIND_CPU);
      add_word(spq_pkg::OP_INSERT, 16'hFFFF, 16'hFFFF, spq_pkg::KIND_GPU);
      add_word(spq_pkg::OP_INSERT, 16'h1111, 16'h0100, spq_pkg::KIND_CPU);
      add_word(spq_pkg::OP_INSERT, 16'h2222, 16'h0100, spq_pkg::KIND_GPU);
      add_word(spq_pkg::OP_INSERT, 16'h3333, 16'h0100, spq_pkg::KIND_CPU);
      add_word(spq_pkg::OP_TAKE,   16'h0000, 16'h0000, spq_pkg::KIND_GPU);
      add_word(spq_pkg::OP_TAKE,   16'h0000, 16'h0000, spq_pkg::KIND_CPU);
      add_word(spq_pkg::OP_TAKE,   16'h0000, 16'h0000, spq_pkg::KIND_CPU);
      add_word(spq_pkg::OP_TAKE,   16'h0000, 16'h0000, spq_pkg::KIND_GPU);
      add_word(spq_pkg::OP_TAKE,   16'h0000, 16'h0000, spq_pkg::KIND_GPU);
      add_word(spq_pkg::OP_TAKE,   16'h0000, 16'h0000, spq_pkg::KIND_GPU);

      // cpu held back at the largest thread count, gpu never held
      set_balance(1'b1, 8'd255);
      add_word(spq_pkg::OP_INSERT, 16'hA5A5, 16'hFFFF, spq_pkg::KIND_CPU);
      add_word(spq_pkg::OP_TAKE,   16'h5A5A, 16'h0000, spq_pkg::KIND_CPU);
      add_word(spq_pkg::OP_TAKE,   16'h5A5A, 16'h0000, spq_pkg::KIND_GPU);

      // exactly at the threshold is granted, one lsb above is held
      set_balance(1'b1, 8'd1);
      add_word(spq_pkg::OP_INSERT, 16'h0F0F, 16'h0100, spq_pkg::KIND_GPU);
      add_word(spq_pkg::OP_TAKE,   16'h0000, 16'h0000, spq_pkg::KIND_CPU);
      add_word(spq_pkg::OP_INSERT, 16'hF0F0, 16'h0101, spq_pkg::KIND_GPU);
      add_word(spq_pkg::OP_TAKE,   16'h0000, 16'h0000, spq_pkg::KIND_CPU);
      add_word(spq_pkg::OP_TAKE,   16'h0000, 16'h0000, spq_pkg::KIND_GPU);

      // random phases, each under its own register setting, with the op mix repeating every six phases
      for (int p = 0; p < PHASES; p++) begin
         set_balance(bal_list[p], thr_list[p]);
         steady = (p % 3 == 2);
         for (int n = 0; n < PHASE_WORDS; n++)
            add_random_word(pct_list[p % 6]);
      end
      wait_idle();

      if (expected_outcomes.size() != 0) begin
         mismatches += expected_outcomes.size();
         $display("%0d expected words never arrived", expected_outcomes.size());
      end
      $display("%0d words over %0d register settings: inserted %0d granted %0d empty %0d",
               words_sent, settings_run, status_seen[spq_pkg::ST_INSERTED],
               status_seen[spq_pkg::ST_GRANTED], status_seen[spq_pkg::ST_EMPTY]);
      $display("held %0d full %0d, %0d responses, %0d mismatches",
               status_seen[spq_pkg::ST_HELD], status_seen[spq_pkg::ST_FULL], results_seen,
               mismatches);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
